FILE: src/assert_macros.svh
// Assertion macros shared by the velocity damping RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising clk edge outside reset.
`define VDSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vdsc assertion failed");
// Check prop at every rising clk edge, reset included.
`define VDSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vdsc assertion failed");
`else
`define VDSC_ASSERT(lbl, prop)
`define VDSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/vdsc_pkg.sv
// Shared types and constants for the velocity damping and speed cap block.
package vdsc_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LANES      = 3;
  localparam int W2         = 2 * WORD_BITS;
  localparam int LIM_BITS   = WORD_BITS - 1;
  localparam int DECAY_BITS = FRAC_BITS + 1;
  localparam int PROD_BITS  = W2 - FRAC_BITS;
  localparam int IDX_BITS   = 2;

  localparam logic [PROD_BITS-1:0] ONE_FIX = PROD_BITS'(1) << FRAC_BITS;

  typedef enum logic [IDX_BITS-1:0] {
    REG_DAMPING = 2'd0,
    REG_FRAME   = 2'd1,
    REG_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [W2-1:0]        dword_t;

  // Per-item sideband that rides alongside the arithmetic.
  typedef struct packed {
    word_t [LANES-1:0] mag;
    logic [LANES-1:0]  neg;
    logic              last;
    logic              capped;
  } side_t;

  // Token of the square-root chain.
  typedef struct packed {
    dword_t x;
    word_t  rem;
    word_t  root;
    side_t  side;
  } sq_tok_t;

  // Token of the divider chain.
  typedef struct packed {
    word_t             len;
    word_t [LANES-1:0] rem;
    word_t [LANES-1:0] dlo;
    word_t [LANES-1:0] quo;
    logic [LANES-1:0]  neg;
    logic              last;
    logic              capped;
  } div_tok_t;

endpackage

FILE: src/vdsc_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module vdsc_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  vdsc_pkg::sq_tok_t in_tok,
  output logic              out_vld,
  output vdsc_pkg::sq_tok_t out_tok
);

  logic [vdsc_pkg::WORD_BITS+1:0] cur;
  logic [vdsc_pkg::WORD_BITS+1:0] trial;
  logic [vdsc_pkg::WORD_BITS+1:0] diff;
  logic                           ge;
  vdsc_pkg::sq_tok_t              tok_nxt;
  vdsc_pkg::sq_tok_t              tok_r;
  logic                           vld_r;

  always_comb begin
    cur     = {in_tok.rem, in_tok.x[vdsc_pkg::W2-1 -: 2]};
    trial   = {in_tok.root, 2'b01};
    ge      = (cur >= trial);
    diff    = cur - trial;
    tok_nxt = in_tok;
    tok_nxt.x    = in_tok.x << 2;
    tok_nxt.rem  = ge ? diff[vdsc_pkg::WORD_BITS-1:0] : cur[vdsc_pkg::WORD_BITS-1:0];
    tok_nxt.root = {in_tok.root[vdsc_pkg::WORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

FILE: src/vdsc_div_cell.sv
// One quotient bit of the pipelined restoring divider, all three lanes.
module vdsc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  vdsc_pkg::div_tok_t in_tok,
  output logic               out_vld,
  output vdsc_pkg::div_tok_t out_tok
);

  logic [vdsc_pkg::LANES-1:0][vdsc_pkg::WORD_BITS:0] cur;
  logic [vdsc_pkg::LANES-1:0][vdsc_pkg::WORD_BITS:0] diff;
  logic [vdsc_pkg::LANES-1:0]                        ge;
  vdsc_pkg::div_tok_t                                tok_nxt;
  vdsc_pkg::div_tok_t                                tok_r;
  logic                                              vld_r;

  always_comb begin
    tok_nxt = in_tok;
    for (int l = 0; l < vdsc_pkg::LANES; l++) begin
      cur[l]  = {in_tok.rem[l], in_tok.dlo[l][vdsc_pkg::WORD_BITS-1]};
      ge[l]   = (cur[l] >= {1'b0, in_tok.len});
      diff[l] = cur[l] - {1'b0, in_tok.len};
      tok_nxt.rem[l] = ge[l] ? diff[l][vdsc_pkg::WORD_BITS-1:0]
                             : cur[l][vdsc_pkg::WORD_BITS-1:0];
      tok_nxt.dlo[l] = in_tok.dlo[l] << 1;
      tok_nxt.quo[l] = {in_tok.quo[l][vdsc_pkg::WORD_BITS-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

FILE: src/velocity_damping_speed_cap.sv
// Top level: velocity damping with speed cap, streaming pipeline of cells.
// Registers in order: front stages, square-root chain, scale setup, divider chain, output register.
// Throughput: one beat per cycle; the whole pipe stalls only while a held output beat sees out_tready low.
// Most of the depth is the square-root chain and the divider chain, one bit per cell.
// Reset (rst_n low, synchronous) clears all valid flags and the three registers to zero.
// Configuration is always ready; write it only while the pipe is empty.
`include "assert_macros.svh"
module velocity_damping_speed_cap (
  input  logic        clk,
  input  logic        rst_n,
  // Input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // vel_x [31:0], vel_y [63:32], vel_z [95:64]
  input  logic        in_tlast,   // last_in
  // Output beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic        out_tuser,  // was_capped
  output logic        out_tlast,  // last_out
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int W = vdsc_pkg::WORD_BITS;
  localparam int F = vdsc_pkg::FRAC_BITS;
  localparam int L = vdsc_pkg::LANES;

  // Configuration registers and the derived constants
  vdsc_pkg::word_t                       coeff_r;
  vdsc_pkg::word_t                       ftime_r;
  logic [vdsc_pkg::LIM_BITS-1:0]         lim_r;
  vdsc_pkg::dword_t                      raw_prod;
  logic [vdsc_pkg::DECAY_BITS-1:0]       decay_r;
  vdsc_pkg::dword_t                      lim_sq_r;
  logic [vdsc_pkg::PROD_BITS-1:0]        prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      ftime_r <= '0;
      lim_r   <= '0;
    end else if (cfg_valid) begin
      case (vdsc_pkg::cfg_reg_t'(cfg_index))
        vdsc_pkg::REG_DAMPING: coeff_r <= cfg_data;
        vdsc_pkg::REG_FRAME:   ftime_r <= cfg_data;
        vdsc_pkg::REG_LIMIT:   lim_r   <= cfg_data[vdsc_pkg::LIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Decay factor: clamp the truncated product to one, then take 1 - product.
  // It is registered in decay_r from the written registers, so the next beat already sees it.
  assign raw_prod = vdsc_pkg::dword_t'(coeff_r) * vdsc_pkg::dword_t'(ftime_r);
  assign prod     = raw_prod[vdsc_pkg::W2-1:F];

  always_ff @(posedge clk) begin
    decay_r    <= (prod >= vdsc_pkg::ONE_FIX) ? '0
                : vdsc_pkg::DECAY_BITS'(vdsc_pkg::ONE_FIX - prod);
    lim_sq_r   <= vdsc_pkg::dword_t'(lim_r) * vdsc_pkg::dword_t'(lim_r);
  end

  // Global advance: the pipe moves whenever the output register can take a beat
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Front stages: split sign, damp, square, sum, cap decision
  logic                              v1_r, v2_r, v3_r, v4_r, v5_r;
  vdsc_pkg::side_t                   s1_r, s2_r, s3_r, s4_r;
  vdsc_pkg::side_t                   s1_nxt, s2_nxt;
  vdsc_pkg::dword_t [L-1:0]          sq3_r;
  vdsc_pkg::dword_t                  sum4_r;
  vdsc_pkg::sq_tok_t                 s5_r;
  vdsc_pkg::sq_tok_t                 s5_nxt;
  logic [W+vdsc_pkg::DECAY_BITS-1:0] damp [L];

  always_comb begin
    s1_nxt = '0;
    for (int l = 0; l < L; l++) begin
      s1_nxt.neg[l] = in_tdata[l*W + W - 1];
      s1_nxt.mag[l] = s1_nxt.neg[l] ? (~in_tdata[l*W +: W] + W'(1)) : in_tdata[l*W +: W];
    end
    s1_nxt.last = in_tlast;
  end

  always_comb begin
    s2_nxt = s1_r;
    for (int l = 0; l < L; l++) begin
      damp[l] = (W + vdsc_pkg::DECAY_BITS)'(s1_r.mag[l]) *
                (W + vdsc_pkg::DECAY_BITS)'(decay_r);
      s2_nxt.mag[l] = damp[l][F +: W];
    end
  end

  always_comb begin
    s5_nxt             = '0;
    s5_nxt.x           = sum4_r;
    s5_nxt.side        = s4_r;
    s5_nxt.side.capped = (lim_r != '0) && (sum4_r > lim_sq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s2_r;
      for (int l = 0; l < L; l++) begin
        sq3_r[l] <= vdsc_pkg::dword_t'(s2_r.mag[l]) * vdsc_pkg::dword_t'(s2_r.mag[l]);
      end
      s4_r   <= s3_r;
      sum4_r <= sq3_r[0] + sq3_r[1] + sq3_r[2];
      s5_r   <= s5_nxt;
    end
  end

  // Square-root chain: one root bit per cell
  logic              sq_vld [W+1];
  vdsc_pkg::sq_tok_t sq_tok [W+1];

  assign sq_vld[0] = v5_r;
  assign sq_tok[0] = s5_r;

  for (genvar g = 0; g < W; g++) begin : g_sqrt
    vdsc_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (sq_vld[g]),
      .in_tok  (sq_tok[g]),
      .out_vld (sq_vld[g+1]),
      .out_tok (sq_tok[g+1])
    );
  end

  // Scale setup: uncapped beats divide by one so the divider passes them through
  vdsc_pkg::sq_tok_t  sq_end;
  vdsc_pkg::div_tok_t s6_nxt;
  vdsc_pkg::div_tok_t s6_r;
  logic               v6_r;
  vdsc_pkg::dword_t   dvd [L];
  vdsc_pkg::word_t    factor;

  assign sq_end = sq_tok[W];

  always_comb begin
    s6_nxt = '0;
    factor = sq_end.side.capped ? W'(lim_r) : W'(1);
    if (sq_end.side.capped && (sq_end.root != '0)) begin
      s6_nxt.len = sq_end.root;
    end else begin
      s6_nxt.len = W'(1);
    end
    for (int l = 0; l < L; l++) begin
      dvd[l] = vdsc_pkg::dword_t'(sq_end.side.mag[l]) * vdsc_pkg::dword_t'(factor);
      s6_nxt.rem[l] = dvd[l][vdsc_pkg::W2-1:W];
      s6_nxt.dlo[l] = dvd[l][W-1:0];
    end
    s6_nxt.neg    = sq_end.side.neg;
    s6_nxt.last   = sq_end.side.last;
    s6_nxt.capped = sq_end.side.capped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= sq_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r <= s6_nxt;
    end
  end

  // Divider chain: one quotient bit per cell
  logic               dv_vld [W+1];
  vdsc_pkg::div_tok_t dv_tok [W+1];

  assign dv_vld[0] = v6_r;
  assign dv_tok[0] = s6_r;

  for (genvar g = 0; g < W; g++) begin : g_div
    vdsc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (dv_vld[g]),
      .in_tok  (dv_tok[g]),
      .out_vld (dv_vld[g+1]),
      .out_tok (dv_tok[g+1])
    );
  end

  // Output register: restore signs and hold the beat until taken
  vdsc_pkg::div_tok_t dv_end;
  logic [95:0]        data_nxt;
  logic               out_vld_r;
  logic [95:0]        out_data_r;
  logic               out_cap_r;
  logic               out_last_r;

  assign dv_end = dv_tok[W];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      data_nxt[l*W +: W] = dv_end.neg[l] ? (~dv_end.quo[l] + W'(1)) : dv_end.quo[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= data_nxt;
      out_cap_r  <= dv_end.capped;
      out_last_r <= dv_end.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cap_r;
  assign out_tlast  = out_last_r;

  `VDSC_ASSERT(a_cap_needs_limit, out_tvalid && out_tuser |-> lim_r != '0)
  `VDSC_ASSERT(a_limit_write, cfg_valid && cfg_index == vdsc_pkg::REG_LIMIT |=> lim_r == $past(cfg_data[vdsc_pkg::LIM_BITS-1:0]))
  `VDSC_ASSERT(a_no_accept_on_stall, in_tvalid && in_tready |-> !(out_tvalid && !out_tready))
  `VDSC_ASSERT_ALWAYS(a_reset_empties, !$past(rst_n) |-> !out_tvalid)

endmodule
